// ----- rtl/strided_transfer_address_walker_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the strided transfer address walker
// Shared property wrappers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef STRIDED_TRANSFER_ADDRESS_WALKER_UNIT_MACROS_SVH
`define STRIDED_TRANSFER_ADDRESS_WALKER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define STAWU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define STAWU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define STAWU_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/stawu_pkg.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker package
// Widths, register indexes, request modes and shared structures.
// ---------------------------------------------------------------------------
package stawu_pkg;

   localparam int ADDR_BITS  = 48;
   localparam int CHUNK_W    = 32;
   localparam int STRIDE_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int LEVEL_W    = 2;
   localparam int MAX_LEVELS = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEVEL_COUNT     = 3'd0,
      CSR_CHUNK_BYTES     = 3'd1,
      CSR_COUNT_LEVEL_ONE = 3'd2,
      CSR_COUNT_LEVEL_TWO = 3'd3,
      CSR_SRC_STRIDE_ONE  = 3'd4,
      CSR_SRC_STRIDE_TWO  = 3'd5,
      CSR_DST_STRIDE_ONE  = 3'd6,
      CSR_DST_STRIDE_TWO  = 3'd7
   } csr_index_type;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_NEXT  = 1'b1
   } mode_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level_count;
      logic [CHUNK_W-1:0]  chunk_bytes;
      logic [COUNT_W-1:0]  count_level_one;
      logic [COUNT_W-1:0]  count_level_two;
      logic [STRIDE_W-1:0] src_stride_one;
      logic [STRIDE_W-1:0] src_stride_two;
      logic [STRIDE_W-1:0] dst_stride_one;
      logic [STRIDE_W-1:0] dst_stride_two;
   } cfg_type;

   typedef struct packed {
      mode_type             mode;
      logic [ADDR_BITS-1:0] src_start;
      logic [ADDR_BITS-1:0] dst_start;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] chunk_src;
      logic [ADDR_BITS-1:0] chunk_dst;
      logic [CHUNK_W-1:0]   chunk_len;
      logic                 last_chunk;
      logic                 no_transfer;
   } rsp_item_type;

endpackage

// ----- rtl/stawu_if.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker channel interfaces
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface stawu_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [stawu_pkg::ADDR_BITS-1:0] src_start;
   logic [stawu_pkg::ADDR_BITS-1:0] dst_start;

   modport source (output valid, output mode, output src_start, output dst_start,
                   input ready);
   modport sink   (input valid, input mode, input src_start, input dst_start,
                   output ready);
endinterface

interface stawu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [stawu_pkg::ADDR_BITS-1:0] chunk_src;
   logic [stawu_pkg::ADDR_BITS-1:0] chunk_dst;
   logic [stawu_pkg::CHUNK_W-1:0]   chunk_len;
   logic                            last_chunk;
   logic                            no_transfer;

   modport source (output valid, output chunk_src, output chunk_dst, output chunk_len,
                   output last_chunk, output no_transfer, input ready);
   modport sink   (input valid, input chunk_src, input chunk_dst, input chunk_len,
                   input last_chunk, input no_transfer, output ready);
endinterface

// ----- rtl/stawu_csr.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker configuration registers
// Write-only register file holding the transfer shape and strides.
// ---------------------------------------------------------------------------
module stawu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [stawu_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [stawu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output stawu_pkg::cfg_type               cfg
);

   stawu_pkg::cfg_type cfg_ff;
   stawu_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (stawu_pkg::csr_index_type'(csr_addr))
            stawu_pkg::CSR_LEVEL_COUNT: begin
               cfg_in.level_count = csr_wdata[stawu_pkg::LEVEL_W-1:0];
            end
            stawu_pkg::CSR_CHUNK_BYTES: begin
               cfg_in.chunk_bytes = csr_wdata[stawu_pkg::CHUNK_W-1:0];
            end
            stawu_pkg::CSR_COUNT_LEVEL_ONE: begin
               cfg_in.count_level_one = csr_wdata[stawu_pkg::COUNT_W-1:0];
            end
            stawu_pkg::CSR_COUNT_LEVEL_TWO: begin
               cfg_in.count_level_two = csr_wdata[stawu_pkg::COUNT_W-1:0];
            end
            stawu_pkg::CSR_SRC_STRIDE_ONE: begin
               cfg_in.src_stride_one = csr_wdata[stawu_pkg::STRIDE_W-1:0];
            end
            stawu_pkg::CSR_SRC_STRIDE_TWO: begin
               cfg_in.src_stride_two = csr_wdata[stawu_pkg::STRIDE_W-1:0];
            end
            stawu_pkg::CSR_DST_STRIDE_ONE: begin
               cfg_in.dst_stride_one = csr_wdata[stawu_pkg::STRIDE_W-1:0];
            end
            stawu_pkg::CSR_DST_STRIDE_TWO: begin
               cfg_in.dst_stride_two = csr_wdata[stawu_pkg::STRIDE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_count     <= '0;
         cfg_ff.chunk_bytes     <= stawu_pkg::CHUNK_W'(1);
         cfg_ff.count_level_one <= stawu_pkg::COUNT_W'(1);
         cfg_ff.count_level_two <= stawu_pkg::COUNT_W'(1);
         cfg_ff.src_stride_one  <= '0;
         cfg_ff.src_stride_two  <= '0;
         cfg_ff.dst_stride_one  <= '0;
         cfg_ff.dst_stride_two  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/stawu_in_stage.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker input stage
// Registers one request beat and hands it to the walker.
// ---------------------------------------------------------------------------
module stawu_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   stawu_req_if.sink               req_bus,
   input  logic                    advance,
   output logic                    item_valid,
   output stawu_pkg::req_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   stawu_pkg::req_item_type item_ff;
   logic                    take;

   // The register empties whenever the walker consumes it, so a new beat can
   // land in the same cycle.
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_bus.ready) begin
         valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.mode      <= stawu_pkg::mode_type'(req_bus.mode);
         item_ff.src_start <= req_bus.src_start;
         item_ff.dst_start <= req_bus.dst_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/stawu_walker.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker core
// Odometer state, next-chunk arithmetic and the response register.
// ---------------------------------------------------------------------------
module stawu_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  stawu_pkg::cfg_type      cfg,
   input  logic                    item_valid,
   input  stawu_pkg::req_item_type item,
   output logic                    advance,
   stawu_rsp_if.source             rsp_bus
);

   localparam int AW = stawu_pkg::ADDR_BITS;
   localparam int CW = stawu_pkg::COUNT_W;
   localparam int LW = stawu_pkg::LEVEL_W;

   logic [AW-1:0] cur_src_ff, cur_src_in;
   logic [AW-1:0] cur_dst_ff, cur_dst_in;
   logic [AW-1:0] row_src_ff, row_src_in;
   logic [AW-1:0] row_dst_ff, row_dst_in;
   logic [CW-1:0] inner_left_ff, inner_left_in;
   logic [CW-1:0] outer_left_ff, outer_left_in;
   logic          busy_ff, busy_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   stawu_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [LW-1:0] eff_levels;
   logic [CW-1:0] c1_minus_one;
   logic [CW-1:0] c2_minus_one;
   logic [AW-1:0] row_src_next;
   logic [AW-1:0] row_dst_next;
   logic          fire;
   logic          last;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign fire    = item_valid && advance;

   // Level counts above the supported depth saturate; a count of zero, or
   // the count of a level that is not in use, behaves as one.
   always_comb begin
      eff_levels = cfg.level_count;
      if (cfg.level_count > LW'(stawu_pkg::MAX_LEVELS)) begin
         eff_levels = LW'(stawu_pkg::MAX_LEVELS);
      end
      c1_minus_one = '0;
      if (eff_levels >= LW'(1) && cfg.count_level_one != '0) begin
         c1_minus_one = cfg.count_level_one - CW'(1);
      end
      c2_minus_one = '0;
      if (eff_levels >= LW'(2) && cfg.count_level_two != '0) begin
         c2_minus_one = cfg.count_level_two - CW'(1);
      end
   end

   assign row_src_next = row_src_ff + AW'(cfg.src_stride_two);
   assign row_dst_next = row_dst_ff + AW'(cfg.dst_stride_two);

   always_comb begin
      cur_src_in    = cur_src_ff;
      cur_dst_in    = cur_dst_ff;
      row_src_in    = row_src_ff;
      row_dst_in    = row_dst_ff;
      inner_left_in = inner_left_ff;
      outer_left_in = outer_left_ff;
      busy_in       = busy_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      last          = 1'b0;

      if (advance) begin
         rsp_valid_in = item_valid;
      end

      if (fire) begin
         if (item.mode == stawu_pkg::MODE_START) begin
            cur_src_in    = item.src_start;
            cur_dst_in    = item.dst_start;
            row_src_in    = item.src_start;
            row_dst_in    = item.dst_start;
            inner_left_in = c1_minus_one;
            outer_left_in = c2_minus_one;
         end else if (busy_ff) begin
            if (inner_left_ff != '0) begin
               inner_left_in = inner_left_ff - CW'(1);
               cur_src_in    = cur_src_ff + AW'(cfg.src_stride_one);
               cur_dst_in    = cur_dst_ff + AW'(cfg.dst_stride_one);
            end else begin
               // End of a row: step the row start and restart the row count.
               outer_left_in = outer_left_ff - CW'(1);
               row_src_in    = row_src_next;
               row_dst_in    = row_dst_next;
               cur_src_in    = row_src_next;
               cur_dst_in    = row_dst_next;
               inner_left_in = c1_minus_one;
            end
         end

         if (item.mode == stawu_pkg::MODE_NEXT && !busy_ff) begin
            rsp_in.chunk_src   = '0;
            rsp_in.chunk_dst   = '0;
            rsp_in.chunk_len   = '0;
            rsp_in.last_chunk  = 1'b0;
            rsp_in.no_transfer = 1'b1;
         end else begin
            last               = (inner_left_in == '0) && (outer_left_in == '0);
            busy_in            = !last;
            rsp_in.chunk_src   = cur_src_in;
            rsp_in.chunk_dst   = cur_dst_in;
            rsp_in.chunk_len   = cfg.chunk_bytes;
            rsp_in.last_chunk  = last;
            rsp_in.no_transfer = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_src_ff    <= '0;
         cur_dst_ff    <= '0;
         row_src_ff    <= '0;
         row_dst_ff    <= '0;
         inner_left_ff <= '0;
         outer_left_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_src_ff    <= cur_src_in;
         cur_dst_ff    <= cur_dst_in;
         row_src_ff    <= row_src_in;
         row_dst_ff    <= row_dst_in;
         inner_left_ff <= inner_left_in;
         outer_left_ff <= outer_left_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.chunk_src   = rsp_ff.chunk_src;
   assign rsp_bus.chunk_dst   = rsp_ff.chunk_dst;
   assign rsp_bus.chunk_len   = rsp_ff.chunk_len;
   assign rsp_bus.last_chunk  = rsp_ff.last_chunk;
   assign rsp_bus.no_transfer = rsp_ff.no_transfer;

endmodule

// ----- rtl/strided_transfer_address_walker_unit.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker
// Walks the chunk list of a transfer with up to two stride levels.
// ---------------------------------------------------------------------------
//
//   Port group   Direction  Moves per beat
//   req_bus      in         mode, src_start, dst_start
//   rsp_bus      out        chunk_src, chunk_dst, chunk_len, last_chunk, no_transfer
//   csr_*        in         one register write per cycle with csr_we high
//
// Every request beat yields exactly one response beat, registered first in the
// input register and then in the walker's response register. A new beat is taken
// every cycle while rsp_bus does not stall.
// A stall on rsp_bus backs up into req_bus through one input register.
// Reset is synchronous; no clearing pass is needed after it.
//
module strided_transfer_address_walker_unit (
   input  logic                             clock,
   input  logic                             reset,
   stawu_req_if.sink                        req_bus,
   stawu_rsp_if.source                      rsp_bus,
   input  logic                             csr_we,
   input  logic [stawu_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [stawu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   stawu_pkg::cfg_type      cfg;
   stawu_pkg::req_item_type item;
   logic                    item_valid;
   logic                    advance;

   stawu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   stawu_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   stawu_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ----- rtl/stawu_checker.sv -----
// ---------------------------------------------------------------------------
// Strided transfer address walker port checker
// Port-level properties, attached to the top level by a bind.
// ---------------------------------------------------------------------------
`include "strided_transfer_address_walker_unit_macros.svh"

module stawu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [stawu_pkg::ADDR_BITS-1:0] chunk_src,
   input logic [stawu_pkg::ADDR_BITS-1:0] chunk_dst,
   input logic [stawu_pkg::CHUNK_W-1:0]   chunk_len,
   input logic                            last_chunk,
   input logic                            no_transfer
);

   // A response beat with no transfer carries no chunk at all.
   `STAWU_ASSERT_NOW(a_no_transfer_empty, clock, reset, rsp_valid && no_transfer,
      chunk_src == '0 && chunk_dst == '0 && chunk_len == '0 && !last_chunk,
      "no-transfer beat carries chunk fields")

   // An accepting response side must never hold back the request side.
   `STAWU_ASSERT_NOW(a_ready_passes_back, clock, reset, rsp_ready, req_ready,
      "request side stalled while response side is ready")

   // A stalled response beat keeps its contents.
   `STAWU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({chunk_src, chunk_dst, chunk_len, last_chunk, no_transfer}),
      "stalled response beat changed")

   // Reset leaves no response pending.
   `STAWU_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "response valid right after reset")

endmodule

bind strided_transfer_address_walker_unit stawu_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .chunk_src   (rsp_bus.chunk_src),
   .chunk_dst   (rsp_bus.chunk_dst),
   .chunk_len   (rsp_bus.chunk_len),
   .last_chunk  (rsp_bus.last_chunk),
   .no_transfer (rsp_bus.no_transfer)
);
